// File: hdl/ps2kc_pkg.sv
// Package with the shared types, codes and the scan code table of the PS/2 controller.
`timescale 1ns / 1ps
package ps2kc_pkg;

    localparam int RAM_BYTES = 32;
    localparam int RAM_AW    = 5;

    // Fixed offsets in the controller RAM
    localparam logic [RAM_AW-1:0] A_CB   = 5'h00;
    localparam logic [RAM_AW-1:0] A_ST   = 5'h01;
    localparam logic [RAM_AW-1:0] A_OB   = 5'h02;
    localparam logic [RAM_AW-1:0] A_LC   = 5'h03;
    localparam logic [RAM_AW-1:0] A_REL  = 5'h04;
    localparam logic [RAM_AW-1:0] A_OP   = 5'h05;
    localparam logic [RAM_AW-1:0] A_PWN  = 5'h06;
    localparam logic [RAM_AW-1:0] A_PWI  = 5'h07;
    localparam logic [RAM_AW-1:0] A_PW0  = 5'h08;
    localparam logic [RAM_AW-1:0] A_SON  = 5'h13;
    localparam logic [RAM_AW-1:0] A_SOFF = 5'h14;
    localparam logic [RAM_AW-1:0] A_MK1  = 5'h16;
    localparam logic [RAM_AW-1:0] A_MK2  = 5'h17;

    // Controller commands written to the command port
    localparam logic [7:0] KC_PW_TEST   = 8'ha4;
    localparam logic [7:0] KC_PW_LOAD   = 8'ha5;
    localparam logic [7:0] KC_PW_ENABLE = 8'ha6;
    localparam logic [7:0] KC_AUX_DIS   = 8'ha7;
    localparam logic [7:0] KC_AUX_EN    = 8'ha8;
    localparam logic [7:0] KC_AUX_TEST  = 8'ha9;
    localparam logic [7:0] KC_SELF_TEST = 8'haa;
    localparam logic [7:0] KC_KBD_TEST  = 8'hab;
    localparam logic [7:0] KC_KBD_DIS   = 8'had;
    localparam logic [7:0] KC_KBD_EN    = 8'hae;
    localparam logic [7:0] KC_RD_INPORT = 8'hc0;
    localparam logic [7:0] KC_RD_OUTP   = 8'hd0;
    localparam logic [7:0] KC_WR_OUTP   = 8'hd1;
    localparam logic [7:0] KC_WR_KBD_OB = 8'hd2;
    localparam logic [7:0] KC_WR_AUX_OB = 8'hd3;
    localparam logic [7:0] KC_WR_AUX    = 8'hd4;
    localparam logic [7:0] KC_A20_OFF   = 8'hdd;
    localparam logic [7:0] KC_A20_ON    = 8'hdf;
    localparam logic [7:0] KC_RD_TESTIN = 8'he0;

    localparam logic [7:0] BYTE_ACK     = 8'hfa;
    localparam logic [7:0] BYTE_NOPW    = 8'hf1;
    localparam logic [7:0] BYTE_TEST_OK = 8'h55;
    localparam logic [7:0] BYTE_RELEASE = 8'hf0;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_OFFER = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       port_select;
        logic [7:0] write_byte;
        logic [7:0] device_byte;
        logic       source_is_aux;
    } t_req;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       device_byte_taken;
        logic       irq_kbd_pulse;
        logic       irq_aux_pulse;
        logic       a20_update;
        logic       a20_level;
        logic       system_reset_request;
        logic       send_valid;
        logic       send_to_aux;
        logic [7:0] send_byte;
    } t_rsp;

    localparam int ROM_DEPTH = 136;

    localparam logic [7:0] SCANCODE_ROM [ROM_DEPTH] = '{
        8'hff, 8'h43, 8'h41, 8'h3f, 8'h3d, 8'h3b, 8'h3c, 8'h58,
        8'h64, 8'h44, 8'h42, 8'h40, 8'h3e, 8'h0f, 8'h29, 8'h59,
        8'h65, 8'h38, 8'h2a, 8'h70, 8'h1d, 8'h10, 8'h02, 8'h5a,
        8'h66, 8'h71, 8'h2c, 8'h1f, 8'h1e, 8'h11, 8'h03, 8'h5b,
        8'h67, 8'h2e, 8'h2d, 8'h20, 8'h12, 8'h05, 8'h04, 8'h5c,
        8'h68, 8'h39, 8'h2f, 8'h21, 8'h14, 8'h13, 8'h06, 8'h5d,
        8'h69, 8'h31, 8'h30, 8'h23, 8'h22, 8'h15, 8'h07, 8'h5e,
        8'h6a, 8'h72, 8'h32, 8'h24, 8'h16, 8'h08, 8'h09, 8'h5f,
        8'h6b, 8'h33, 8'h25, 8'h17, 8'h18, 8'h0b, 8'h0a, 8'h60,
        8'h6c, 8'h34, 8'h35, 8'h26, 8'h27, 8'h19, 8'h0c, 8'h61,
        8'h6d, 8'h73, 8'h28, 8'h74, 8'h1a, 8'h0d, 8'h62, 8'h6e,
        8'h3a, 8'h36, 8'h1c, 8'h1b, 8'h75, 8'h2b, 8'h63, 8'h76,
        8'h55, 8'h56, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h0e, 8'h7b,
        8'h7c, 8'h4f, 8'h7d, 8'h4b, 8'h47, 8'h7e, 8'h7f, 8'h6f,
        8'h52, 8'h53, 8'h50, 8'h4c, 8'h4d, 8'h48, 8'h01, 8'h45,
        8'h57, 8'h4e, 8'h51, 8'h4a, 8'h37, 8'h49, 8'h46, 8'h54,
        8'h80, 8'h81, 8'h82, 8'h41, 8'h54, 8'h85, 8'h86, 8'h87
    };

    // Set 2 to set 1; codes past the table map to themselves
    function automatic logic [7:0] set1_of(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b < 8'(ROM_DEPTH)) begin
            r = SCANCODE_ROM[b];
        end
        return r;
    endfunction

endpackage

// File: hdl/ps2kc_if.sv
// Request and response channel interfaces of the PS/2 controller.
`timescale 1ns / 1ps
interface ps2kc_req_if;
    logic              valid;
    logic              ready;
    ps2kc_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ps2kc_rsp_if;
    logic              valid;
    logic              ready;
    ps2kc_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/ps2_keyboard_controller_unit.sv
// Top level of the 8042-style PS/2 keyboard controller.
`timescale 1ns / 1ps
// The controller takes one request per clock: a host read or write of the
// data or status/command port, a byte offered by the keyboard or aux device,
// or a controller reset. Each request gives exactly one response: it waits
// in the input register, then makes one pass through the decode logic into
// the response register, which also updates the 32-byte controller RAM held
// in flip-flops. A request can be accepted in every cycle, so the sustained
// rate is one request per clock; it is limited only by the single RAM update
// per request and by the response side taking results. While a response is
// stalled, one further request can enter and wait in the input register;
// after that the input side stalls until the response is taken. A refused
// device byte still gives a response, with device_byte_taken low. After
// reset the RAM holds the command byte 0x41, status 0x10 and output port
// 0x03, the same as after a reset request.
module ps2_keyboard_controller_unit #(
    parameter int PASSWORD_BYTES = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ps2kc_req_if.sink     i_req,
    ps2kc_rsp_if.source   o_rsp
);

    localparam logic [7:0] PW_LAST = 8'(PASSWORD_BYTES - 1);
    localparam logic [7:0] PW_FULL = 8'(PASSWORD_BYTES) + 8'h08;

    logic              r_in_valid;
    ps2kc_pkg::t_req   r_in;
    logic              r_out_valid;
    ps2kc_pkg::t_rsp   r_out;
    logic [7:0]        r_ram [ps2kc_pkg::RAM_BYTES];
    logic [7:0]        n_ram [ps2kc_pkg::RAM_BYTES];
    ps2kc_pkg::t_rsp   n_out;
    logic              advance;

    // The processing stage moves when the response register is free or emptying.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ps2kc_pkg::RAM_BYTES; k++) begin
                r_ram[k] <= 8'h00;
            end
            r_ram[ps2kc_pkg::A_CB] <= 8'h41;
            r_ram[ps2kc_pkg::A_ST] <= 8'h10;
            r_ram[ps2kc_pkg::A_OP] <= 8'h03;
        end else if (advance) begin
            r_ram <= n_ram;
        end
    end

    // One request's work. A byte for the output buffer is gathered first and
    // then passed once through the password filter and the buffer update.
    always_comb begin
        logic [7:0] m [ps2kc_pkg::RAM_BYTES];
        logic       del_req;
        logic       del_aux;
        logic [7:0] del_b;
        logic       xl_req;
        logic [7:0] xl_b;
        logic [7:0] wb;
        logic [7:0] lc;
        logic       done;
        logic       swallow;
        logic [7:0] pwi;
        logic       a20_sig;

        m       = r_ram;
        n_out   = '0;
        del_req = 1'b0;
        del_aux = 1'b0;
        del_b   = 8'h00;
        xl_req  = 1'b0;
        xl_b    = 8'h00;
        wb      = r_in.write_byte;
        lc      = r_ram[ps2kc_pkg::A_LC];
        done    = 1'b0;
        swallow = 1'b0;
        pwi     = 8'h00;
        a20_sig = 1'b0;

        case (ps2kc_pkg::t_cmd'(r_in.command))
            ps2kc_pkg::CMD_READ: begin
                if (!r_in.port_select) begin
                    n_out.read_byte    = m[ps2kc_pkg::A_OB];
                    m[ps2kc_pkg::A_ST] = m[ps2kc_pkg::A_ST] & ~8'h21;
                    m[ps2kc_pkg::A_OP] = m[ps2kc_pkg::A_OP] & ~8'h30;
                end else begin
                    n_out.read_byte = (m[ps2kc_pkg::A_ST] & ~8'h04)
                                    | (m[ps2kc_pkg::A_CB] & 8'h04);
                end
            end
            ps2kc_pkg::CMD_WRITE: begin
                if (m[ps2kc_pkg::A_ST][4] && !r_in.port_select) begin
                    if (m[ps2kc_pkg::A_ST][3]) begin
                        done = 1'b1;
                        if (lc inside {[8'h60:8'h7f]}) begin
                            m[lc[4:0]] = wb;
                        end else begin
                            case (lc)
                                ps2kc_pkg::KC_PW_LOAD: begin
                                    if (m[ps2kc_pkg::A_PWN] <= PW_LAST) begin
                                        m[5'(m[ps2kc_pkg::A_PWN] + 8'h08)] = wb;
                                        m[ps2kc_pkg::A_PWN] = m[ps2kc_pkg::A_PWN] + 8'h01;
                                        if (wb == 8'h00) begin
                                            m[ps2kc_pkg::A_PWN] = PW_FULL;
                                        end
                                    end
                                end
                                ps2kc_pkg::KC_WR_OUTP: begin
                                    m[ps2kc_pkg::A_OP] = wb;
                                    a20_sig = 1'b1;
                                    n_out.system_reset_request = !wb[0];
                                end
                                ps2kc_pkg::KC_WR_KBD_OB: begin
                                    xl_req  = 1'b1;
                                    xl_b    = wb;
                                    del_req = 1'b1;
                                end
                                ps2kc_pkg::KC_WR_AUX_OB: begin
                                    del_req = 1'b1;
                                    del_aux = 1'b1;
                                    del_b   = wb;
                                end
                                ps2kc_pkg::KC_WR_AUX: begin
                                    n_out.send_valid  = 1'b1;
                                    n_out.send_to_aux = 1'b1;
                                    n_out.send_byte   = wb;
                                end
                                ps2kc_pkg::KC_A20_OFF: begin
                                    m[ps2kc_pkg::A_OP] = m[ps2kc_pkg::A_OP] & ~8'h02;
                                    a20_sig = 1'b1;
                                end
                                ps2kc_pkg::KC_A20_ON: begin
                                    m[ps2kc_pkg::A_OP] = m[ps2kc_pkg::A_OP] | 8'h02;
                                    a20_sig = 1'b1;
                                end
                                default: begin
                                    done = 1'b0;
                                end
                            endcase
                        end
                    end
                    m[ps2kc_pkg::A_ST] = m[ps2kc_pkg::A_ST] & ~8'h08;
                    if (!done) begin
                        n_out.send_valid = 1'b1;
                        n_out.send_byte  = wb;
                    end
                end else if (m[ps2kc_pkg::A_ST][4]) begin
                    m[ps2kc_pkg::A_LC] = wb;
                    m[ps2kc_pkg::A_ST] = m[ps2kc_pkg::A_ST] | 8'h08;
                    if (wb inside {[8'h20:8'h3f]}) begin
                        del_req = 1'b1;
                        del_b   = m[wb[4:0]];
                    end else if (wb >= 8'hf0) begin
                        n_out.system_reset_request = !wb[0];
                    end else begin
                        case (wb)
                            ps2kc_pkg::KC_PW_TEST: begin
                                del_req = 1'b1;
                                del_b   = (m[ps2kc_pkg::A_PWN] != 8'h00)
                                        ? ps2kc_pkg::BYTE_ACK : ps2kc_pkg::BYTE_NOPW;
                            end
                            ps2kc_pkg::KC_PW_ENABLE: begin
                                m[ps2kc_pkg::A_ST]  = m[ps2kc_pkg::A_ST] & ~8'h10;
                                m[ps2kc_pkg::A_PWI] = 8'h00;
                                if (m[ps2kc_pkg::A_SON] != 8'h00) begin
                                    m[ps2kc_pkg::A_OB] = m[ps2kc_pkg::A_SON];
                                    m[ps2kc_pkg::A_ST] = (m[ps2kc_pkg::A_ST] & ~8'h21) | 8'h01;
                                    n_out.irq_kbd_pulse = m[ps2kc_pkg::A_CB][0];
                                end
                            end
                            ps2kc_pkg::KC_AUX_DIS: begin
                                m[ps2kc_pkg::A_CB] = m[ps2kc_pkg::A_CB] | 8'h20;
                            end
                            ps2kc_pkg::KC_AUX_EN: begin
                                m[ps2kc_pkg::A_CB] = m[ps2kc_pkg::A_CB] & ~8'h20;
                            end
                            ps2kc_pkg::KC_AUX_TEST, ps2kc_pkg::KC_KBD_TEST,
                            ps2kc_pkg::KC_RD_INPORT, ps2kc_pkg::KC_RD_TESTIN: begin
                                del_req = 1'b1;
                            end
                            ps2kc_pkg::KC_SELF_TEST: begin
                                del_req = 1'b1;
                                del_b   = ps2kc_pkg::BYTE_TEST_OK;
                            end
                            ps2kc_pkg::KC_KBD_DIS: begin
                                m[ps2kc_pkg::A_CB] = m[ps2kc_pkg::A_CB] | 8'h10;
                            end
                            ps2kc_pkg::KC_KBD_EN: begin
                                m[ps2kc_pkg::A_CB] = m[ps2kc_pkg::A_CB] & ~8'h10;
                            end
                            ps2kc_pkg::KC_RD_OUTP: begin
                                del_req = 1'b1;
                                del_b   = m[ps2kc_pkg::A_OP];
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ps2kc_pkg::CMD_OFFER: begin
                if (!m[ps2kc_pkg::A_ST][0] &&
                    !(r_in.source_is_aux ? m[ps2kc_pkg::A_CB][5] : m[ps2kc_pkg::A_CB][4])) begin
                    n_out.device_byte_taken = 1'b1;
                    del_req = 1'b1;
                    if (r_in.source_is_aux) begin
                        del_aux = 1'b1;
                        del_b   = r_in.device_byte;
                    end else begin
                        xl_req = 1'b1;
                        xl_b   = r_in.device_byte;
                    end
                end
            end
            ps2kc_pkg::CMD_RESET: begin
                for (int k = 0; k < ps2kc_pkg::RAM_BYTES; k++) begin
                    m[k] = 8'h00;
                end
                m[ps2kc_pkg::A_CB] = 8'h41;
                m[ps2kc_pkg::A_ST] = 8'h10;
                m[ps2kc_pkg::A_OP] = 8'h03;
            end
            default: begin
            end
        endcase

        // Set 2 to set 1 translation when command byte bit 6 is set; a release
        // prefix is then remembered, and from a keyboard offer it puts nothing in the buffer.
        if (xl_req) begin
            del_b = xl_b;
            if (m[ps2kc_pkg::A_CB][6] && xl_b == ps2kc_pkg::BYTE_RELEASE) begin
                m[ps2kc_pkg::A_REL] = 8'h01;
                if (ps2kc_pkg::t_cmd'(r_in.command) == ps2kc_pkg::CMD_OFFER) begin
                    del_req = 1'b0;
                end
            end else begin
                if (m[ps2kc_pkg::A_CB][6]) begin
                    del_b = ps2kc_pkg::set1_of(xl_b);
                    if (m[ps2kc_pkg::A_REL] != 8'h00) begin
                        del_b = del_b | 8'h80;
                    end
                end
                m[ps2kc_pkg::A_REL] = 8'h00;
            end
        end

        // Password filter, then the output buffer and interrupts.
        if (del_req) begin
            if (!m[ps2kc_pkg::A_ST][4]) begin
                swallow = 1'b1;
                if (!(del_b[7] || del_b == m[ps2kc_pkg::A_MK1] ||
                      del_b == m[ps2kc_pkg::A_MK2] || del_aux)) begin
                    pwi = m[ps2kc_pkg::A_PWI];
                    if (del_b == m[5'(pwi + 8'h08)]) begin
                        pwi = pwi + 8'h01;
                    end else begin
                        pwi = 8'h00;
                    end
                    m[ps2kc_pkg::A_PWI] = pwi;
                    if (pwi > PW_LAST || m[5'(pwi[2:0]) + ps2kc_pkg::A_PW0] == 8'h00) begin
                        m[ps2kc_pkg::A_ST] = m[ps2kc_pkg::A_ST] | 8'h10;
                        if (m[ps2kc_pkg::A_SOFF] != 8'h00) begin
                            del_b   = m[ps2kc_pkg::A_SOFF];
                            swallow = 1'b0;
                        end
                    end
                end
            end
            if (!swallow) begin
                m[ps2kc_pkg::A_OB] = del_b;
                m[ps2kc_pkg::A_ST] = (m[ps2kc_pkg::A_ST] & ~8'h21)
                                   | (del_aux ? 8'h21 : 8'h01);
                if (del_aux && m[ps2kc_pkg::A_CB][1]) begin
                    m[ps2kc_pkg::A_OP]  = m[ps2kc_pkg::A_OP] | 8'h20;
                    n_out.irq_aux_pulse = 1'b1;
                end else if (!del_aux && m[ps2kc_pkg::A_CB][0]) begin
                    m[ps2kc_pkg::A_OP]  = m[ps2kc_pkg::A_OP] | 8'h10;
                    n_out.irq_kbd_pulse = 1'b1;
                end
            end
        end

        if (a20_sig) begin
            n_out.a20_update = 1'b1;
            n_out.a20_level  = m[ps2kc_pkg::A_OP][1];
        end

        n_ram = m;
    end

`ifndef SYNTHESIS
    // A reset request leaves the command byte at its reset value.
    a_reset_cb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.command == ps2kc_pkg::CMD_RESET |=> r_ram[ps2kc_pkg::A_CB] == 8'h41)
        else $error("command byte wrong after reset request");

    // Only one interrupt is raised per response.
    a_one_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.irq_kbd_pulse && r_out.irq_aux_pulse))
        else $error("both interrupts raised");

    // The input side stalls only when the input register is holding a request.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_in_valid && r_out_valid)
        else $error("input stalled without cause");

    // A stalled response is not overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_out))
        else $error("response lost while stalled");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the PS/2 keyboard controller unit.
`timescale 1ns / 1ps
module testbench;

    localparam int PW_LEN     = 7;
    localparam int IDLE_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    ps2kc_req_if req_ch ();
    ps2kc_rsp_if rsp_ch ();

    ps2_keyboard_controller_unit #(.PASSWORD_BYTES(PW_LEN)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Shadow copy of the controller state and the results it should give.
    logic [7:0]        kc_ram [ps2kc_pkg::RAM_BYTES];
    ps2kc_pkg::t_rsp   cur_rsp;
    ps2kc_pkg::t_rsp   rsp_expected [$];
    ps2kc_pkg::t_req   pending_req [$];

    int n_req_done;
    int n_rsp_checked;
    int n_errors;
    int n_taken;
    int n_irq;
    int idle_cycles;

    function automatic void kc_reset_state();
        foreach (kc_ram[i]) kc_ram[i] = 8'h00;
        kc_ram[ps2kc_pkg::A_CB] = 8'h41;
        kc_ram[ps2kc_pkg::A_ST] = 8'h10;
        kc_ram[ps2kc_pkg::A_OP] = 8'h03;
    endfunction

    function automatic logic [7:0] kc_translate(input logic [7:0] b);
        logic [7:0] t;
        t = b;
        if (kc_ram[ps2kc_pkg::A_CB][6]) begin
            if (b == ps2kc_pkg::BYTE_RELEASE) begin
                kc_ram[ps2kc_pkg::A_REL] = 8'h01;
                return b;
            end
            t = ps2kc_pkg::set1_of(b);
            if (kc_ram[ps2kc_pkg::A_REL] != 8'h00) t = t | 8'h80;
        end
        kc_ram[ps2kc_pkg::A_REL] = 8'h00;
        return t;
    endfunction

    // Returns 1 when the keyboard is inhibited and the byte is swallowed.
    function automatic bit kc_inhibit_eats(inout logic [7:0] b, input bit aux);
        logic [4:0] idx;
        if (kc_ram[ps2kc_pkg::A_ST][4]) return 1'b0;
        if (b >= 8'h80 || b == kc_ram[ps2kc_pkg::A_MK1] || b == kc_ram[ps2kc_pkg::A_MK2]
            || aux) return 1'b1;
        idx = 5'(kc_ram[ps2kc_pkg::A_PWI] + 8'd8);
        if (b == kc_ram[idx]) kc_ram[ps2kc_pkg::A_PWI] = kc_ram[ps2kc_pkg::A_PWI] + 8'd1;
        else kc_ram[ps2kc_pkg::A_PWI] = 8'h00;
        if (kc_ram[ps2kc_pkg::A_PWI] > 8'(PW_LEN - 1)
            || kc_ram[5'(kc_ram[ps2kc_pkg::A_PWI] + 8'd8)] == 8'h00) begin
            kc_ram[ps2kc_pkg::A_ST] = kc_ram[ps2kc_pkg::A_ST] | 8'h10;
            if (kc_ram[ps2kc_pkg::A_SOFF] != 8'h00) begin
                b = kc_ram[ps2kc_pkg::A_SOFF];
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void kc_fill_buffer(input logic [7:0] b_in, input bit aux);
        logic [7:0] b;
        b = b_in;
        if (kc_inhibit_eats(b, aux)) return;
        kc_ram[ps2kc_pkg::A_OB] = b;
        kc_ram[ps2kc_pkg::A_ST] = (kc_ram[ps2kc_pkg::A_ST] & ~8'h21) | (aux ? 8'h21 : 8'h01);
        if (aux && kc_ram[ps2kc_pkg::A_CB][1]) begin
            kc_ram[ps2kc_pkg::A_OP] = kc_ram[ps2kc_pkg::A_OP] | 8'h20;
            cur_rsp.irq_aux_pulse = 1'b1;
        end else if (!aux && kc_ram[ps2kc_pkg::A_CB][0]) begin
            kc_ram[ps2kc_pkg::A_OP] = kc_ram[ps2kc_pkg::A_OP] | 8'h10;
            cur_rsp.irq_kbd_pulse = 1'b1;
        end
    endfunction

    function automatic void kc_a20();
        cur_rsp.a20_update = 1'b1;
        cur_rsp.a20_level  = kc_ram[ps2kc_pkg::A_OP][1];
    endfunction

    function automatic void kc_send(input logic [7:0] b, input bit aux);
        cur_rsp.send_valid  = 1'b1;
        cur_rsp.send_to_aux = aux;
        cur_rsp.send_byte   = b;
    endfunction

    function automatic void kc_data_write(input logic [7:0] b);
        bit         claimed;
        logic [7:0] lc;
        claimed = 1'b0;
        lc = kc_ram[ps2kc_pkg::A_LC];
        if (kc_ram[ps2kc_pkg::A_ST][3]) begin
            claimed = 1'b1;
            if (lc >= 8'h60 && lc <= 8'h7f) begin
                kc_ram[5'(lc - 8'h60)] = b;
            end else if (lc == ps2kc_pkg::KC_PW_LOAD) begin
                if (kc_ram[ps2kc_pkg::A_PWN] <= 8'(PW_LEN - 1)) begin
                    kc_ram[5'(kc_ram[ps2kc_pkg::A_PWN] + 8'd8)] = b;
                    kc_ram[ps2kc_pkg::A_PWN] = kc_ram[ps2kc_pkg::A_PWN] + 8'd1;
                    if (b == 8'h00) kc_ram[ps2kc_pkg::A_PWN] = 8'(PW_LEN + 8);
                end
            end else if (lc == ps2kc_pkg::KC_WR_OUTP) begin
                kc_ram[ps2kc_pkg::A_OP] = b;
                kc_a20();
                if (!b[0]) cur_rsp.system_reset_request = 1'b1;
            end else if (lc == ps2kc_pkg::KC_WR_KBD_OB) begin
                kc_fill_buffer(kc_translate(b), 1'b0);
            end else if (lc == ps2kc_pkg::KC_WR_AUX_OB) begin
                kc_fill_buffer(b, 1'b1);
            end else if (lc == ps2kc_pkg::KC_WR_AUX) begin
                kc_send(b, 1'b1);
            end else if (lc == ps2kc_pkg::KC_A20_OFF) begin
                kc_ram[ps2kc_pkg::A_OP] = kc_ram[ps2kc_pkg::A_OP] & ~8'h02;
                kc_a20();
            end else if (lc == ps2kc_pkg::KC_A20_ON) begin
                kc_ram[ps2kc_pkg::A_OP] = kc_ram[ps2kc_pkg::A_OP] | 8'h02;
                kc_a20();
            end else begin
                claimed = 1'b0;
            end
        end
        kc_ram[ps2kc_pkg::A_ST] = kc_ram[ps2kc_pkg::A_ST] & ~8'h08;
        if (!claimed) kc_send(b, 1'b0);
    endfunction

    function automatic void kc_command_write(input logic [7:0] b);
        kc_ram[ps2kc_pkg::A_LC] = b;
        kc_ram[ps2kc_pkg::A_ST] = kc_ram[ps2kc_pkg::A_ST] | 8'h08;
        if (b >= 8'h20 && b <= 8'h3f) begin
            kc_fill_buffer(kc_ram[5'(b - 8'h20)], 1'b0);
        end else if (b >= 8'hf0) begin
            if (!b[0]) cur_rsp.system_reset_request = 1'b1;
        end else begin
            case (b)
                ps2kc_pkg::KC_PW_TEST: begin
                    kc_fill_buffer((kc_ram[ps2kc_pkg::A_PWN] != 8'h00)
                                   ? ps2kc_pkg::BYTE_ACK : ps2kc_pkg::BYTE_NOPW, 1'b0);
                end
                ps2kc_pkg::KC_PW_ENABLE: begin
                    kc_ram[ps2kc_pkg::A_ST]  = kc_ram[ps2kc_pkg::A_ST] & ~8'h10;
                    kc_ram[ps2kc_pkg::A_PWI] = 8'h00;
                    if (kc_ram[ps2kc_pkg::A_SON] != 8'h00) begin
                        kc_ram[ps2kc_pkg::A_OB] = kc_ram[ps2kc_pkg::A_SON];
                        kc_ram[ps2kc_pkg::A_ST] = (kc_ram[ps2kc_pkg::A_ST] & ~8'h21) | 8'h01;
                        if (kc_ram[ps2kc_pkg::A_CB][0]) cur_rsp.irq_kbd_pulse = 1'b1;
                    end
                end
                ps2kc_pkg::KC_AUX_DIS:
                    kc_ram[ps2kc_pkg::A_CB] = kc_ram[ps2kc_pkg::A_CB] | 8'h20;
                ps2kc_pkg::KC_AUX_EN:
                    kc_ram[ps2kc_pkg::A_CB] = kc_ram[ps2kc_pkg::A_CB] & ~8'h20;
                ps2kc_pkg::KC_AUX_TEST, ps2kc_pkg::KC_KBD_TEST,
                ps2kc_pkg::KC_RD_INPORT, ps2kc_pkg::KC_RD_TESTIN: begin
                    kc_fill_buffer(8'h00, 1'b0);
                end
                ps2kc_pkg::KC_SELF_TEST: kc_fill_buffer(ps2kc_pkg::BYTE_TEST_OK, 1'b0);
                ps2kc_pkg::KC_KBD_DIS:
                    kc_ram[ps2kc_pkg::A_CB] = kc_ram[ps2kc_pkg::A_CB] | 8'h10;
                ps2kc_pkg::KC_KBD_EN:
                    kc_ram[ps2kc_pkg::A_CB] = kc_ram[ps2kc_pkg::A_CB] & ~8'h10;
                ps2kc_pkg::KC_RD_OUTP: kc_fill_buffer(kc_ram[ps2kc_pkg::A_OP], 1'b0);
                default: ;
            endcase
        end
    endfunction

    function automatic void kc_offer(input logic [7:0] b, input bit aux);
        logic [7:0] t;
        if (kc_ram[ps2kc_pkg::A_ST][0]) return;
        if (aux ? kc_ram[ps2kc_pkg::A_CB][5] : kc_ram[ps2kc_pkg::A_CB][4]) return;
        cur_rsp.device_byte_taken = 1'b1;
        if (aux) begin
            kc_fill_buffer(b, 1'b1);
        end else begin
            t = kc_translate(b);
            if (kc_ram[ps2kc_pkg::A_REL] == 8'h00) kc_fill_buffer(t, 1'b0);
        end
    endfunction

    function automatic ps2kc_pkg::t_rsp predict_response(input ps2kc_pkg::t_req r);
        cur_rsp = '0;
        case (ps2kc_pkg::t_cmd'(r.command))
            ps2kc_pkg::CMD_READ: begin
                if (!r.port_select) begin
                    cur_rsp.read_byte = kc_ram[ps2kc_pkg::A_OB];
                    kc_ram[ps2kc_pkg::A_ST] = kc_ram[ps2kc_pkg::A_ST] & ~8'h21;
                    kc_ram[ps2kc_pkg::A_OP] = kc_ram[ps2kc_pkg::A_OP] & ~8'h30;
                end else begin
                    cur_rsp.read_byte = (kc_ram[ps2kc_pkg::A_ST] & ~8'h04)
                                      | (kc_ram[ps2kc_pkg::A_CB] & 8'h04);
                end
            end
            ps2kc_pkg::CMD_WRITE: begin
                if (kc_ram[ps2kc_pkg::A_ST][4]) begin
                    if (!r.port_select) kc_data_write(r.write_byte);
                    else kc_command_write(r.write_byte);
                end
            end
            ps2kc_pkg::CMD_OFFER: kc_offer(r.device_byte, r.source_is_aux);
            default:   kc_reset_state();
        endcase
        return cur_rsp;
    endfunction

    // Request builders; fields that the command ignores carry random noise.
    function automatic ps2kc_pkg::t_req mk_req(input ps2kc_pkg::t_cmd c, input bit sel,
                                               input logic [7:0] wb);
        ps2kc_pkg::t_req r;
        r.command       = c;
        r.port_select   = sel;
        r.write_byte    = wb;
        r.device_byte   = 8'($urandom);
        r.source_is_aux = 1'($urandom);
        return r;
    endfunction

    function automatic ps2kc_pkg::t_req mk_offer(input logic [7:0] b, input bit aux);
        ps2kc_pkg::t_req r;
        r = mk_req(ps2kc_pkg::CMD_OFFER, 1'($urandom), 8'($urandom));
        r.device_byte   = b;
        r.source_is_aux = aux;
        return r;
    endfunction

    function automatic void push_cmd(input logic [7:0] c);
        pending_req.push_back(mk_req(ps2kc_pkg::CMD_WRITE, 1'b1, c));
    endfunction

    function automatic void push_data(input logic [7:0] d);
        pending_req.push_back(mk_req(ps2kc_pkg::CMD_WRITE, 1'b0, d));
    endfunction

    function automatic void push_read(input bit sel);
        pending_req.push_back(mk_req(ps2kc_pkg::CMD_READ, sel, 8'($urandom)));
    endfunction

    function automatic void push_ram_write(input logic [4:0] a, input logic [7:0] d);
        push_cmd(8'h60 + 8'(a));
        push_data(d);
    endfunction

    // Commands worth hitting often in the random part.
    logic [7:0] known_cmds [] = '{
        ps2kc_pkg::KC_PW_TEST, ps2kc_pkg::KC_PW_LOAD, ps2kc_pkg::KC_PW_ENABLE,
        ps2kc_pkg::KC_AUX_DIS, ps2kc_pkg::KC_AUX_EN, ps2kc_pkg::KC_AUX_TEST,
        ps2kc_pkg::KC_SELF_TEST, ps2kc_pkg::KC_KBD_TEST, ps2kc_pkg::KC_KBD_DIS,
        ps2kc_pkg::KC_KBD_EN, ps2kc_pkg::KC_RD_INPORT, ps2kc_pkg::KC_RD_OUTP,
        ps2kc_pkg::KC_WR_OUTP, ps2kc_pkg::KC_WR_KBD_OB, ps2kc_pkg::KC_WR_AUX_OB,
        ps2kc_pkg::KC_WR_AUX, ps2kc_pkg::KC_A20_OFF, ps2kc_pkg::KC_A20_ON,
        ps2kc_pkg::KC_RD_TESTIN, 8'h20, 8'h3f, 8'hfe, 8'hff, 8'h00
    };

    // Resets the controller, loads a password, arms the inhibit and types the
    // password back, sometimes with a random byte offered before one of its bytes.
    function automatic void push_password_session();
        int         len;
        logic [7:0] pw [PW_LEN];
        len = $urandom_range(1, PW_LEN);
        pending_req.push_back(mk_req(ps2kc_pkg::CMD_RESET, 1'($urandom), 8'($urandom)));
        push_ram_write(ps2kc_pkg::A_CB, ($urandom_range(0, 3) == 0) ? 8'h43 : 8'h03);
        push_ram_write(ps2kc_pkg::A_SOFF,
                       ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
        push_ram_write(ps2kc_pkg::A_SON,
                       ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
        if ($urandom_range(0, 2) == 0)
            push_ram_write(ps2kc_pkg::A_MK1, 8'($urandom_range(1, 127)));
        push_cmd(ps2kc_pkg::KC_PW_LOAD);
        for (int i = 0; i < len; i++) begin
            pw[i] = 8'($urandom_range(1, 127));
            push_data(pw[i]);
            if (i + 1 < len) push_cmd(ps2kc_pkg::KC_PW_LOAD);
        end
        if (len < PW_LEN) begin
            push_cmd(ps2kc_pkg::KC_PW_LOAD);
            push_data(8'h00);
        end
        push_cmd(ps2kc_pkg::KC_PW_TEST);
        push_read(1'b0);
        push_cmd(ps2kc_pkg::KC_PW_ENABLE);
        push_read(1'b0);
        push_data(8'($urandom));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                pending_req.push_back(mk_offer(8'($urandom), 1'($urandom)));
            pending_req.push_back(mk_offer(pw[i], 1'b0));
        end
        push_read(1'b1);
        push_read(1'b0);
    endfunction

    function automatic void push_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            push_read(1'($urandom));
        end else if (pick < 40) begin
            if ($urandom_range(0, 3) == 0)
                pending_req.push_back(mk_offer(ps2kc_pkg::BYTE_RELEASE, 1'b0));
            pending_req.push_back(mk_offer(8'($urandom), 1'($urandom)));
            if ($urandom_range(0, 1) == 0) push_read(1'b0);
        end else if (pick < 60) begin
            push_cmd(known_cmds[$urandom_range(0, known_cmds.size() - 1)]);
            if ($urandom_range(0, 2) != 0) push_data(8'($urandom));
            push_read(1'b0);
        end else if (pick < 72) begin
            push_ram_write(5'($urandom), 8'($urandom));
            push_cmd(8'h20 + 8'($urandom_range(0, 31)));
            push_read(1'b0);
        end else if (pick < 80) begin
            push_cmd(8'($urandom));
        end else if (pick < 88) begin
            push_data(8'($urandom));
        end else if (pick < 96) begin
            push_password_session();
        end else begin
            pending_req.push_back(mk_req(ps2kc_pkg::CMD_RESET, 1'($urandom), 8'($urandom)));
        end
    endfunction

    // Per-request wait, with every third hundred of requests run without gaps.
    function automatic int draw_wait(input int count);
        if ((count / 100) % 3 == 2) return 0;
        return $urandom_range(0, 6);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, name,
                     exp_v, act_v);
            n_errors++;
        end
    endfunction

    // Request driver.
    int drv_wait;
    always @(posedge i_clk) begin
        ps2kc_pkg::t_rsp p;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            drv_wait = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                p = predict_response(req_ch.data);
                rsp_expected.push_back(p);
                n_req_done++;
                if (p.device_byte_taken) n_taken++;
                if (p.irq_kbd_pulse || p.irq_aux_pulse) n_irq++;
            end
            if (req_ch.valid && !req_ch.ready) begin
                // Hold the current request until it is taken.
            end else if (drv_wait > 0) begin
                drv_wait--;
                req_ch.valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
                req_ch.data  <= pending_req.pop_front();
                req_ch.valid <= 1'b1;
                drv_wait = draw_wait(n_req_done);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor, with one long hold-off to fill the block up.
    int  mon_wait;
    int  hold_left;
    bit  hold_done;
    always @(posedge i_clk) begin
        ps2kc_pkg::t_rsp e;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            mon_wait = 0;
            hold_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (rsp_expected.size() == 0) begin
                    $display("%0t: response with none expected, got %0h", $realtime,
                             rsp_ch.data);
                    n_errors++;
                end else begin
                    e = rsp_expected.pop_front();
                    check_field("read_byte", e.read_byte, rsp_ch.data.read_byte);
                    check_field("device_byte_taken", 8'(e.device_byte_taken),
                                8'(rsp_ch.data.device_byte_taken));
                    check_field("irq_kbd_pulse", 8'(e.irq_kbd_pulse),
                                8'(rsp_ch.data.irq_kbd_pulse));
                    check_field("irq_aux_pulse", 8'(e.irq_aux_pulse),
                                8'(rsp_ch.data.irq_aux_pulse));
                    check_field("a20_update", 8'(e.a20_update), 8'(rsp_ch.data.a20_update));
                    check_field("a20_level", 8'(e.a20_level), 8'(rsp_ch.data.a20_level));
                    check_field("system_reset_request", 8'(e.system_reset_request),
                                8'(rsp_ch.data.system_reset_request));
                    check_field("send_valid", 8'(e.send_valid), 8'(rsp_ch.data.send_valid));
                    check_field("send_to_aux", 8'(e.send_to_aux), 8'(rsp_ch.data.send_to_aux));
                    check_field("send_byte", e.send_byte, rsp_ch.data.send_byte);
                end
                n_rsp_checked++;
                mon_wait = draw_wait(n_rsp_checked + 50);
            end
            if (!hold_done && n_rsp_checked >= 300) begin
                hold_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (mon_wait > 0) begin
                mon_wait--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        n_req_done = 0;
        n_rsp_checked = 0;
        n_errors = 0;
        n_taken = 0;
        n_irq = 0;
        idle_cycles = 0;
        hold_done = 1'b0;
        kc_reset_state();

        // Directed part: status, self-tests, RAM access, A20, forwarding.
        push_read(1'b1);
        push_read(1'b0);
        push_cmd(ps2kc_pkg::KC_SELF_TEST);
        push_read(1'b0);
        push_ram_write(5'h1f, 8'hff);
        push_cmd(8'h3f);
        push_read(1'b0);
        push_cmd(ps2kc_pkg::KC_WR_OUTP);
        push_data(8'hfe);
        push_cmd(ps2kc_pkg::KC_A20_OFF);
        push_cmd(ps2kc_pkg::KC_A20_ON);
        push_cmd(ps2kc_pkg::KC_WR_AUX);
        push_data(8'hff);
        push_cmd(8'hc7);
        push_data(8'h00);
        push_cmd(8'hf0);
        // Release prefix with translation on, then a key code, and an aux byte offered while the buffer is full.
        pending_req.push_back(mk_offer(ps2kc_pkg::BYTE_RELEASE, 1'b0));
        pending_req.push_back(mk_offer(8'h1c, 1'b0));
        pending_req.push_back(mk_offer(8'hff, 1'b1));
        push_read(1'b0);
        pending_req.push_back(mk_offer(8'h00, 1'b1));
        push_read(1'b0);
        push_cmd(ps2kc_pkg::KC_WR_AUX_OB);
        push_data(8'h80);
        pending_req.push_back(mk_req(ps2kc_pkg::CMD_RESET, 1'b1, 8'hff));

        while (pending_req.size() < 1000) push_random_item();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_req.size() == 0 && !req_ch.valid);
        wait (rsp_expected.size() == 0);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d responses to %0d requests; %0d device bytes taken,",
                 n_rsp_checked, n_req_done, n_taken);
        $display("%0d interrupts, password sessions and one long response hold-off.", n_irq);
        if (n_errors == 0 && rsp_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
